// File: hdl/matrix_power_2x2_top_assert.svh
// Assertion macros for the 2x2 matrix power block.
`ifndef MATRIX_POWER_2X2_TOP_ASSERT_SVH
`define MATRIX_POWER_2X2_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MP2_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MP2_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mp2_pkg.sv
// Shared types and constants for the 2x2 matrix power block.
package mp2_pkg;

   localparam int DATA_W            = 64;
   localparam int HALF_W            = 32;
   localparam int EXP_FIELD_W       = 8;
   localparam int EXPONENT_BITS_DEF = 8;

   // Matrix entry index {row, column}.
   localparam int               ENTRY_W    = 2;
   localparam logic [ENTRY_W-1:0] ENTRY_LAST = 2'd3;

   // Partial product codes of one 64x64 low product.
   localparam int              PART_W    = 2;
   localparam logic [PART_W-1:0] PART_LO   = 2'd0;  // a_lo * b_lo
   localparam logic [PART_W-1:0] PART_HI_B = 2'd1;  // a_lo * b_hi, shifted up
   localparam logic [PART_W-1:0] PART_HI_A = 2'd2;  // a_hi * b_lo, shifted up

   // Control word for the multiply-accumulate unit.
   typedef struct packed {
      logic               valid;
      logic               clear;
      logic               high;
      logic               last;
      logic [ENTRY_W-1:0] tag;
   } mac_ctl_type;

   // Status word back from the multiply-accumulate unit.
   typedef struct packed {
      logic               done;
      logic [ENTRY_W-1:0] tag;
   } mac_sts_type;

endpackage

// File: hdl/mp2_req_if.sv
// Request channel carrying the base matrix and the exponent.
interface mp2_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mp2_pkg::DATA_W-1:0]   base_00;
   logic signed [mp2_pkg::DATA_W-1:0]   base_01;
   logic signed [mp2_pkg::DATA_W-1:0]   base_10;
   logic signed [mp2_pkg::DATA_W-1:0]   base_11;
   logic [mp2_pkg::EXP_FIELD_W-1:0]     exponent;

   modport source (output valid, base_00, base_01, base_10, base_11, exponent,
                   input ready);
   modport sink (input valid, base_00, base_01, base_10, base_11, exponent,
                 output ready);
endinterface

// File: hdl/mp2_rsp_if.sv
// Response channel carrying the powered matrix.
interface mp2_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mp2_pkg::DATA_W-1:0] power_00;
   logic signed [mp2_pkg::DATA_W-1:0] power_01;
   logic signed [mp2_pkg::DATA_W-1:0] power_10;
   logic signed [mp2_pkg::DATA_W-1:0] power_11;

   modport source (output valid, power_00, power_01, power_10, power_11,
                   input ready);
   modport sink (input valid, power_00, power_01, power_10, power_11,
                 output ready);
endinterface

// File: hdl/mp2_mac.sv
// Shared 32x32 multiplier with a 64-bit wrapping accumulator.
module mp2_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  mp2_pkg::mac_ctl_type            ctl,
   input  logic [mp2_pkg::HALF_W-1:0]      opa,
   input  logic [mp2_pkg::HALF_W-1:0]      opb,
   output mp2_pkg::mac_sts_type            sts,
   output logic [mp2_pkg::DATA_W-1:0]      sum
);

   mp2_pkg::mac_ctl_type            ctl_ff;
   mp2_pkg::mac_sts_type            sts_ff, sts_in;
   logic [mp2_pkg::DATA_W-1:0]      prod_ff, prod_in;
   logic [mp2_pkg::DATA_W-1:0]      sum_ff, sum_in;
   logic [mp2_pkg::DATA_W-1:0]      shifted;
   logic [mp2_pkg::DATA_W-1:0]      addend;

   // Stage one: one unsigned 32x32 partial product.
   assign prod_in = mp2_pkg::DATA_W'(opa) * mp2_pkg::DATA_W'(opb);

   // Stage two: align the partial product and add it into the running sum.
   always_comb begin
      shifted = ctl_ff.high ? {prod_ff[mp2_pkg::HALF_W-1:0], {mp2_pkg::HALF_W{1'b0}}}
                            : prod_ff;
      addend  = ctl_ff.clear ? '0 : sum_ff;
      sum_in  = ctl_ff.valid ? addend + shifted : sum_ff;
      sts_in.done = ctl_ff.valid & ctl_ff.last;
      sts_in.tag  = ctl_ff.tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         sts_ff <= '0;
      end else begin
         ctl_ff <= ctl;
         sts_ff <= sts_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sts = sts_ff;
   assign sum = sum_ff;

endmodule

// File: hdl/mp2_ctrl.sv
// Sequencer and matrix registers that drive the shared multiply-accumulate unit.
module mp2_ctrl #(
   parameter int EXPONENT_BITS = mp2_pkg::EXPONENT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   mp2_req_if.sink                     req_ch,
   mp2_rsp_if.source                   rsp_ch,
   output mp2_pkg::mac_ctl_type        mac_ctl,
   output logic [mp2_pkg::HALF_W-1:0]  mac_opa,
   output logic [mp2_pkg::HALF_W-1:0]  mac_opb,
   input  mp2_pkg::mac_sts_type        mac_sts,
   input  logic [mp2_pkg::DATA_W-1:0]  mac_sum
);

   localparam int BIT_IDX_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;
   localparam logic [BIT_IDX_W-1:0] BIT_TOP = BIT_IDX_W'(EXPONENT_BITS - 1);

   localparam int         ST_W      = 3;
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_COPY   = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   localparam int DW = mp2_pkg::DATA_W;
   localparam int HW = mp2_pkg::HALF_W;

   // Control registers.
   logic [ST_W-1:0]                 state_ff, state_in;
   logic [BIT_IDX_W-1:0]            bit_ff, bit_in;
   logic                            seen_ff, seen_in;
   logic                            op_mul_ff, op_mul_in;
   logic [mp2_pkg::ENTRY_W-1:0]     entry_ff, entry_in;
   logic                            term_ff, term_in;
   logic [mp2_pkg::PART_W-1:0]      part_ff, part_in;

   // Payload registers.
   logic [EXPONENT_BITS-1:0]        expo_ff;
   logic [DW-1:0] base_00_ff, base_01_ff, base_10_ff, base_11_ff;
   logic [DW-1:0] acc_00_ff, acc_01_ff, acc_10_ff, acc_11_ff;
   logic [DW-1:0] acc_00_in, acc_01_in, acc_10_in, acc_11_in;
   logic [DW-1:0] res_00_ff, res_01_ff, res_10_ff, res_11_ff;

   logic          accept;
   logic          cur_bit;
   logic [DW-1:0] a_word;
   logic [DW-1:0] b_word;

   // Picks one entry of a matrix by its {row, column} index.
   function automatic logic [DW-1:0] pick(input logic [DW-1:0] m00,
                                          input logic [DW-1:0] m01,
                                          input logic [DW-1:0] m10,
                                          input logic [DW-1:0] m11,
                                          input logic [1:0]    idx);
      logic [DW-1:0] r;
      case (idx)
         2'd0:    r = m00;
         2'd1:    r = m01;
         2'd2:    r = m10;
         default: r = m11;
      endcase
      return r;
   endfunction

   assign accept  = req_ch.valid && req_ch.ready;
   assign cur_bit = expo_ff[bit_ff];

   // Operand selection: left factor is always the running product, right
   // factor is either the running product (square) or the base.
   always_comb begin
      a_word = pick(acc_00_ff, acc_01_ff, acc_10_ff, acc_11_ff, {entry_ff[1], term_ff});
      if (op_mul_ff) begin
         b_word = pick(base_00_ff, base_01_ff, base_10_ff, base_11_ff,
                       {term_ff, entry_ff[0]});
      end else begin
         b_word = pick(acc_00_ff, acc_01_ff, acc_10_ff, acc_11_ff, {term_ff, entry_ff[0]});
      end
      mac_opa = (part_ff == mp2_pkg::PART_HI_A) ? a_word[DW-1:HW] : a_word[HW-1:0];
      mac_opb = (part_ff == mp2_pkg::PART_HI_B) ? b_word[DW-1:HW] : b_word[HW-1:0];
      mac_ctl.valid = (state_ff == ST_ISSUE);
      mac_ctl.clear = !term_ff && (part_ff == mp2_pkg::PART_LO);
      mac_ctl.high  = (part_ff != mp2_pkg::PART_LO);
      mac_ctl.last  = term_ff && (part_ff == mp2_pkg::PART_HI_A);
      mac_ctl.tag   = entry_ff;
   end

   // Sequencer: scans exponent bits from the top, squaring and multiplying.
   always_comb begin
      state_in  = state_ff;
      bit_in    = bit_ff;
      seen_in   = seen_ff;
      op_mul_in = op_mul_ff;
      entry_in  = entry_ff;
      term_in   = term_ff;
      part_in   = part_ff;
      acc_00_in = acc_00_ff;
      acc_01_in = acc_01_ff;
      acc_10_in = acc_10_ff;
      acc_11_in = acc_11_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bit_in    = BIT_TOP;
               seen_in   = 1'b0;
               op_mul_in = 1'b0;
               entry_in  = '0;
               term_in   = 1'b0;
               part_in   = mp2_pkg::PART_LO;
               acc_00_in = DW'(1);
               acc_01_in = '0;
               acc_10_in = '0;
               acc_11_in = DW'(1);
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (seen_ff) begin
               op_mul_in = 1'b0;
               state_in  = ST_ISSUE;
            end else begin
               // Until the first one bit the product is the identity, so
               // squaring is skipped and the first multiply is a copy.
               if (cur_bit) begin
                  seen_in   = 1'b1;
                  acc_00_in = base_00_ff;
                  acc_01_in = base_01_ff;
                  acc_10_in = base_10_ff;
                  acc_11_in = base_11_ff;
               end
               if (bit_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            if (part_ff == mp2_pkg::PART_HI_A) begin
               part_in = mp2_pkg::PART_LO;
               term_in = !term_ff;
               if (term_ff) begin
                  entry_in = entry_ff + 1'b1;
                  if (entry_ff == mp2_pkg::ENTRY_LAST) begin
                     state_in = ST_DRAIN;
                  end
               end
            end else begin
               part_in = part_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (mac_sts.done && (mac_sts.tag == mp2_pkg::ENTRY_LAST)) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            acc_00_in = res_00_ff;
            acc_01_in = res_01_ff;
            acc_10_in = res_10_ff;
            acc_11_in = res_11_ff;
            if (!op_mul_ff && cur_bit) begin
               op_mul_in = 1'b1;
               state_in  = ST_ISSUE;
            end else if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bit_ff    <= '0;
         seen_ff   <= 1'b0;
         op_mul_ff <= 1'b0;
         entry_ff  <= '0;
         term_ff   <= 1'b0;
         part_ff   <= mp2_pkg::PART_LO;
      end else begin
         state_ff  <= state_in;
         bit_ff    <= bit_in;
         seen_ff   <= seen_in;
         op_mul_ff <= op_mul_in;
         entry_ff  <= entry_in;
         term_ff   <= term_in;
         part_ff   <= part_in;
      end
   end

   // Matrix and exponent storage.
   always_ff @(posedge clock) begin
      acc_00_ff <= acc_00_in;
      acc_01_ff <= acc_01_in;
      acc_10_ff <= acc_10_in;
      acc_11_ff <= acc_11_in;
      if (accept) begin
         expo_ff    <= EXPONENT_BITS'(req_ch.exponent);
         base_00_ff <= req_ch.base_00;
         base_01_ff <= req_ch.base_01;
         base_10_ff <= req_ch.base_10;
         base_11_ff <= req_ch.base_11;
      end
      if (mac_sts.done) begin
         case (mac_sts.tag)
            2'd0:    res_00_ff <= mac_sum;
            2'd1:    res_01_ff <= mac_sum;
            2'd2:    res_10_ff <= mac_sum;
            default: res_11_ff <= mac_sum;
         endcase
      end
   end

   // Channel outputs.
   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = (state_ff == ST_OUT);
   assign rsp_ch.power_00 = acc_00_ff;
   assign rsp_ch.power_01 = acc_01_ff;
   assign rsp_ch.power_10 = acc_10_ff;
   assign rsp_ch.power_11 = acc_11_ff;

endmodule

// File: hdl/matrix_power_2x2_top.sv
// Top level of the 2x2 matrix power block.
//
// Usage: the request channel carries a 2x2 matrix of signed 64-bit entries
// and an 8-bit exponent; the response channel returns the matrix raised to
// that power, every entry wrapped to 64 bits. Exponent zero gives identity.
// Only the low EXPONENT_BITS bits of the exponent are used.
// One word is in flight at a time: ready drops after a request is taken and
// returns in the cycle after the response word is taken.
// Every matrix product is eight 64-bit products, each built from three
// passes through one shared 32x32 multiplier; after the issue passes the
// multiplier drains and one copy step loads the result into the product.
// With L the position of the highest set exponent bit plus one and P the
// number of set bits, the block runs L-1 squares and P-1 multiplies, plus one
// decision step per exponent bit. The response holds, unchanged, for as
// long as the receiver stalls.
// Synchronous reset returns the block to idle and drops any work under way.
module matrix_power_2x2_top #(
   parameter int EXPONENT_BITS = mp2_pkg::EXPONENT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   mp2_req_if.sink    req_ch,
   mp2_rsp_if.source  rsp_ch
);

   `include "matrix_power_2x2_top_assert.svh"

   mp2_pkg::mac_ctl_type            mac_ctl;
   mp2_pkg::mac_sts_type            mac_sts;
   logic [mp2_pkg::HALF_W-1:0]      mac_opa;
   logic [mp2_pkg::HALF_W-1:0]      mac_opb;
   logic [mp2_pkg::DATA_W-1:0]      mac_sum;

   // Sequencer with the matrix registers.
   mp2_ctrl #(
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .mac_ctl (mac_ctl),
      .mac_opa (mac_opa),
      .mac_opb (mac_opb),
      .mac_sts (mac_sts),
      .mac_sum (mac_sum)
   );

   // Shared multiply-accumulate unit.
   mp2_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .opa   (mac_opa),
      .opb   (mac_opb),
      .sts   (mac_sts),
      .sum   (mac_sum)
   );

   // The block never offers to take a word while a response is pending.
   `MP2_ASSERT_SAME(a_ready_vs_result, req_ch.ready, !rsp_ch.valid, "ready with result pending")

   // A taken request makes the block busy on the next cycle.
   `MP2_ASSERT_NEXT(a_busy_after_req, req_ch.valid && req_ch.ready, !req_ch.ready, "not busy")

   // A taken response returns the block to idle on the next cycle.
   `MP2_ASSERT_NEXT(a_idle_after_rsp, rsp_ch.valid && rsp_ch.ready,
                    req_ch.ready && !rsp_ch.valid, "not idle after response")

endmodule
